>>> src/yxcw_pkg.sv
`default_nettype none
package yxcw_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_FORMAT_MODE    = 3'd0;
  localparam logic [2:0] REG_SOURCE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_SOURCE_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_DISPLAY_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DISPLAY_HEIGHT = 3'd4;
  localparam logic [2:0] REG_DISPLAY_PITCH  = 3'd5;

  // register reset values
  localparam logic        RST_FORMAT_MODE    = 1'b0;
  localparam logic [12:0] RST_SOURCE_WIDTH   = 13'd1920;
  localparam logic [12:0] RST_SOURCE_HEIGHT  = 13'd1080;
  localparam logic [12:0] RST_DISPLAY_WIDTH  = 13'd1920;
  localparam logic [12:0] RST_DISPLAY_HEIGHT = 13'd1080;
  localparam logic [14:0] RST_DISPLAY_PITCH  = 15'd7680;

  // format codes
  localparam logic FMT_YUV = 1'b0;
  localparam logic FMT_RGB = 1'b1;

  localparam int unsigned ADDR_W = 26;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned PITCH_W = 15;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // bt.601 integer coefficients
  localparam logic signed [19:0] K_Y     = 20'sd298;
  localparam logic signed [19:0] K_RV    = 20'sd409;
  localparam logic signed [19:0] K_GU    = 20'sd100;
  localparam logic signed [19:0] K_GV    = 20'sd208;
  localparam logic signed [19:0] K_BU    = 20'sd516;
  localparam logic signed [19:0] K_RND   = 20'sd128;
  localparam logic signed [9:0]  Y_OFS   = 10'sd16;
  localparam logic signed [9:0]  C_OFS   = 10'sd128;
  localparam logic [7:0]         ALPHA   = 8'hFF;

  // position lookup result for one beat
  typedef struct packed {
    logic              keep;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } pos_t;

  // zero counts as one, above the max counts as the max
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = 13'd1;
    end else if (v > MAX_DIM) begin
      r = MAX_DIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // floor shift by 8 and clamp to a byte
  function automatic logic [7:0] clamp8(input logic signed [19:0] acc);
    logic [7:0] r;
    if (acc[19]) begin
      r = 8'd0;
    end else if (|acc[18:16]) begin
      r = 8'd255;
    end else begin
      r = acc[15:8];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/yxcw_pos.sv
`default_nettype none
module yxcw_pos import yxcw_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic               start_of_frame_i,
  input  wire logic [DIM_W-1:0]   source_width_i,
  input  wire logic [DIM_W-1:0]   source_height_i,
  input  wire logic [DIM_W-1:0]   display_width_i,
  input  wire logic [DIM_W-1:0]   display_height_i,
  input  wire logic [PITCH_W-1:0] display_pitch_i,
  output pos_t                    pos_o
);

  logic [POS_W-1:0]  column_q, column_d;
  logic [POS_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] row_base_q, row_base_d;

  logic [DIM_W-1:0]  sw, sh, dw, dh, vw, vh;
  logic [POS_W-1:0]  col_cur, row_cur;
  logic [ADDR_W-1:0] base_cur;
  logic [DIM_W-1:0]  col_inc, row_inc;

  // effective and visible sizes
  always_comb begin
    sw = eff_dim(source_width_i);
    sh = eff_dim(source_height_i);
    dw = eff_dim(display_width_i);
    dh = eff_dim(display_height_i);
    vw = (sw < dw) ? sw : dw;
    vh = (sh < dh) ? sh : dh;
  end

  // position of this beat, start of frame forces the origin
  always_comb begin
    col_cur  = start_of_frame_i ? '0 : column_q;
    row_cur  = start_of_frame_i ? '0 : row_q;
    base_cur = start_of_frame_i ? '0 : row_base_q;
    col_inc  = {1'b0, col_cur} + 13'd1;
    row_inc  = {1'b0, row_cur} + 13'd1;
  end

  // crop test, last flag and address
  always_comb begin
    pos_o.keep = ({1'b0, col_cur} < vw) && ({1'b0, row_cur} < vh);
    pos_o.last = (col_inc == vw) && (row_inc == vh);
    pos_o.addr = base_cur + {{(ADDR_W-POS_W-2){1'b0}}, col_cur, 2'b00};
  end

  // raster advance
  always_comb begin
    column_d   = column_q;
    row_d      = row_q;
    row_base_d = row_base_q;
    if (accept_i) begin
      if (col_inc >= sw) begin
        column_d = '0;
        if (row_inc >= sh) begin
          row_d      = '0;
          row_base_d = '0;
        end else begin
          row_d      = row_inc[POS_W-1:0];
          row_base_d = base_cur + {{(ADDR_W-PITCH_W){1'b0}}, display_pitch_i};
        end
      end else begin
        column_d   = col_inc[POS_W-1:0];
        row_d      = row_cur;
        row_base_d = base_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q   <= '0;
      row_q      <= '0;
      row_base_q <= '0;
    end else begin
      column_q   <= column_d;
      row_q      <= row_d;
      row_base_q <= row_base_d;
    end
  end

endmodule
`default_nettype wire

>>> src/yxcw_csc.sv
`default_nettype none
module yxcw_csc import yxcw_pkg::*; (
  input  wire logic        format_mode_i,
  input  wire logic [7:0]  first_i,
  input  wire logic [7:0]  second_i,
  input  wire logic [7:0]  third_i,
  output logic      [31:0] word_o
);

  logic signed [9:0]  c_s, d_s, e_s;
  logic signed [19:0] c_w, d_w, e_w;
  logic signed [19:0] r_acc, g_acc, b_acc;
  logic        [7:0]  r, g, b;

  // centered samples
  always_comb begin
    c_s = $signed({2'b00, first_i}) - Y_OFS;
    d_s = $signed({2'b00, second_i}) - C_OFS;
    e_s = $signed({2'b00, third_i}) - C_OFS;
    c_w = 20'(c_s);
    d_w = 20'(d_s);
    e_w = 20'(e_s);
  end

  // constant coefficient products and clamp
  always_comb begin
    r_acc = K_Y * c_w + K_RV * e_w + K_RND;
    g_acc = K_Y * c_w - K_GU * d_w - K_GV * e_w + K_RND;
    b_acc = K_Y * c_w + K_BU * d_w + K_RND;
    r = clamp8(r_acc);
    g = clamp8(g_acc);
    b = clamp8(b_acc);
  end

  // pack xrgb, pass-through keeps byte order third/second/first
  always_comb begin
    if (format_mode_i == FMT_RGB) begin
      word_o = {ALPHA, third_i, second_i, first_i};
    end else begin
      word_o = {ALPHA, r, g, b};
    end
  end

endmodule
`default_nettype wire

>>> src/yuv_to_xrgb_crop_writer.sv
// an input beat passes the input register, then the result register, as a result beat
// throughput: one pixel per cycle when not stalled; cropped pixels are dropped, no beat
// a result stall reaches the input stall combinationally through both registers
// reset: asynchronous active low, clears position counters, valids and config to defaults
`default_nettype none
module yuv_to_xrgb_crop_writer import yxcw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // pixel input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        start_of_frame_i,
  input  wire logic [7:0]  first_sample_i,
  input  wire logic [7:0]  second_sample_i,
  input  wire logic [7:0]  third_sample_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [25:0]      byte_address_o,
  output logic [31:0]      pixel_word_o,
  output logic             last_visible_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);

  logic               format_mode_q;
  logic [DIM_W-1:0]   source_width_q, source_height_q;
  logic [DIM_W-1:0]   display_width_q, display_height_q;
  logic [PITCH_W-1:0] display_pitch_q;

  logic               in_accept;
  pos_t               pos;

  logic               s1_valid_q;
  logic [7:0]         s1_first_q, s1_second_q, s1_third_q;
  logic [ADDR_W-1:0]  s1_addr_q;
  logic               s1_last_q;

  logic               out_valid_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic [31:0]        out_word_q;
  logic               out_last_q;

  logic               out_free, s1_free;
  logic [31:0]        word;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_mode_q    <= RST_FORMAT_MODE;
      source_width_q   <= RST_SOURCE_WIDTH;
      source_height_q  <= RST_SOURCE_HEIGHT;
      display_width_q  <= RST_DISPLAY_WIDTH;
      display_height_q <= RST_DISPLAY_HEIGHT;
      display_pitch_q  <= RST_DISPLAY_PITCH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FORMAT_MODE:    format_mode_q    <= cfg_data_i[0];
        REG_SOURCE_WIDTH:   source_width_q   <= cfg_data_i[DIM_W-1:0];
        REG_SOURCE_HEIGHT:  source_height_q  <= cfg_data_i[DIM_W-1:0];
        REG_DISPLAY_WIDTH:  display_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_DISPLAY_HEIGHT: display_height_q <= cfg_data_i[DIM_W-1:0];
        REG_DISPLAY_PITCH:  display_pitch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: each stage moves when the next one is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign in_accept  = in_valid_i && s1_free;

  // raster position and crop
  yxcw_pos u_pos (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .start_of_frame_i (start_of_frame_i),
    .source_width_i   (source_width_q),
    .source_height_i  (source_height_q),
    .display_width_i  (display_width_q),
    .display_height_i (display_height_q),
    .display_pitch_i  (display_pitch_q),
    .pos_o            (pos)
  );

  // input register, only kept pixels occupy it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_accept && pos.keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_first_q  <= first_sample_i;
      s1_second_q <= second_sample_i;
      s1_third_q  <= third_sample_i;
      s1_addr_q   <= pos.addr;
      s1_last_q   <= pos.last;
    end
  end

  // color conversion
  yxcw_csc u_csc (
    .format_mode_i (format_mode_q),
    .first_i       (s1_first_q),
    .second_i      (s1_second_q),
    .third_i       (s1_third_q),
    .word_o        (word)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_addr_q <= s1_addr_q;
      out_word_q <= word;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_address_o = out_addr_q;
  assign pixel_word_o   = out_word_q;
  assign last_visible_o = out_last_q;

endmodule
`default_nettype wire
